// File: hw/rtl/element_heat_conduction_step_defines.svh
// assertion macros for the element heat conduction step block
`ifndef ELEMENT_HEAT_CONDUCTION_STEP_DEFINES_SVH
`define ELEMENT_HEAT_CONDUCTION_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define EHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EHC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EHC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EHC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/ehc_pkg.sv
// shared types and constants for the element heat conduction step block
package ehc_pkg;
    localparam int MAX_NODES_DEF = 8;
    localparam int DIMS_DEF      = 3;
    localparam int SLOTS         = 8;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic signed [31:0] node_temp;
        logic [30:0]        node_mass;
        logic [23:0]        node_index;
        logic signed [31:0] conductance_volume;
        logic               last_node;
    } ehc_in_t;

    typedef struct packed {
        logic signed [31:0] temp_increment;
        logic [23:0]        out_node_index;
        logic               last_result;
    } ehc_out_t;

    // one element job handed from front to back
    typedef struct packed {
        logic signed [31:0] sum_x;
        logic signed [31:0] sum_y;
        logic signed [31:0] sum_z;
        logic signed [31:0] conductance;
        logic [3:0]         count;
    } ehc_job_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction
endpackage

// File: hw/rtl/ehc_ram.sv
// generic single write port ram with registered read
module ehc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// File: hw/rtl/ehc_front.sv
// front end: stores node data and accumulates the weighted temperature sums
module ehc_front
    import ehc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int DIMS      = DIMS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ehc_in_t         s_data,
    // node store write side
    output logic            st_we,
    output logic [2:0]      st_addr,
    output logic [150:0]    st_wdata,
    // job to the queue
    output logic            job_valid,
    input  logic            job_ready,
    output ehc_job_t        job
);
    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_PUSH} state_t;

    state_t             state_reg;
    ehc_in_t            item_reg;
    logic signed [63:0] sum_reg [3];
    logic signed [63:0] prod_reg [3];
    logic signed [31:0] cond_reg;
    logic [3:0]         count_reg;
    logic [1:0]         d_reg;

    logic store_ok;
    logic signed [31:0] g_sel;
    assign store_ok = count_reg < 4'(MAX_NODES);
    assign s_ready  = (state_reg == ST_IDLE);
    assign st_we    = s_valid && s_ready && store_ok;
    assign st_addr  = count_reg[2:0];
    assign st_wdata = {s_data.grad_x, s_data.grad_y,
                       (DIMS >= 3) ? s_data.grad_z : 32'sd0,
                       s_data.node_mass, s_data.node_index};
    assign job_valid = (state_reg == ST_PUSH);
    assign job.sum_x = sat32(66'(sum_reg[0]));
    assign job.sum_y = sat32(66'(sum_reg[1]));
    assign job.sum_z = sat32(66'(sum_reg[2]));
    assign job.conductance = cond_reg;
    assign job.count = count_reg;

    always_comb begin
        case (d_reg)
            2'd0:    g_sel = item_reg.grad_x;
            2'd1:    g_sel = item_reg.grad_y;
            default: g_sel = item_reg.grad_z;
        endcase
    end

    // one multiply per dimension, then accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cond_reg  <= '0;
            d_reg     <= '0;
            for (int d = 0; d < 3; d++) begin
                sum_reg[d] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        d_reg    <= '0;
                        if (store_ok) begin
                            if (count_reg == 4'd0) begin
                                cond_reg <= s_data.conductance_volume;
                            end
                            state_reg <= ST_MUL;
                        end else if (s_data.last_node) begin
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_MUL: begin
                    prod_reg[d_reg] <= g_sel * item_reg.node_temp;
                    if (d_reg == 2'(DIMS - 1)) begin
                        state_reg <= ST_ACC;
                    end
                    d_reg <= d_reg + 2'd1;
                end
                ST_ACC: begin
                    for (int d = 0; d < DIMS; d++) begin
                        sum_reg[d] <= sum_reg[d] + (prod_reg[d] >>> 16);
                    end
                    count_reg <= count_reg + 4'd1;
                    state_reg <= item_reg.last_node ? ST_PUSH : ST_IDLE;
                end
                ST_PUSH: begin
                    if (job_ready) begin
                        state_reg <= ST_IDLE;
                        count_reg <= '0;
                        for (int d = 0; d < 3; d++) begin
                            sum_reg[d] <= '0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/ehc_back.sv
// back end: per node dot product, scaling and division by the mass
module ehc_back
    import ehc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [30:0]  time_step,
    input  logic         job_valid,
    output logic         job_ready,
    input  ehc_job_t     job,
    output logic [2:0]   rd_addr,
    input  logic [150:0] rd_data,
    output logic         m_valid,
    input  logic         m_ready,
    output ehc_out_t     m_data
);
    typedef enum logic [2:0] {B_IDLE, B_READ, B_MUL, B_DOT, B_FLUX,
                              B_NUM, B_DIV, B_OUT} bstate_t;

    bstate_t            state_reg;
    ehc_job_t           job_reg;
    logic [2:0]         idx_reg;
    logic [1:0]         d_reg;
    logic signed [31:0] g_reg [3];
    logic [30:0]        mass_reg;
    logic [23:0]        nidx_reg;
    logic signed [63:0] p_reg [3];
    logic signed [31:0] dot_reg;
    logic signed [31:0] flux_reg;
    logic [62:0]        rem_reg;
    logic [62:0]        quo_reg;
    logic               neg_reg;
    logic [5:0]         bit_reg;
    ehc_out_t           out_reg;
    logic               out_valid_reg;

    logic signed [31:0] s_sel, g_sel;
    logic signed [65:0] dot_sum;
    logic signed [63:0] flux_prod;
    logic signed [63:0] num_full;
    logic [63:0]        trial;
    logic signed [63:0] qs;

    always_comb begin
        case (d_reg)
            2'd0:    begin s_sel = job_reg.sum_x; g_sel = g_reg[0]; end
            2'd1:    begin s_sel = job_reg.sum_y; g_sel = g_reg[1]; end
            default: begin s_sel = job_reg.sum_z; g_sel = g_reg[2]; end
        endcase
    end
    assign dot_sum  = 66'(p_reg[0] >>> 16) + 66'(p_reg[1] >>> 16) + 66'(p_reg[2] >>> 16);
    assign flux_prod = dot_reg * job_reg.conductance;
    assign num_full = $signed({1'b0, time_step}) * flux_reg;
    assign trial    = {rem_reg, quo_reg[62]} - {33'd0, mass_reg};
    assign qs       = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    assign job_ready = (state_reg == B_IDLE);
    assign rd_addr   = idx_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // node walk: one restoring division bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            // drop valid after a transfer unless a new result loads
            if (m_valid && m_ready && state_reg != B_OUT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    idx_reg <= '0;
                    if (job_valid) begin
                        job_reg   <= job;
                        state_reg <= (job.count == 4'd0) ? B_IDLE : B_READ;
                    end
                end
                B_READ: begin
                    state_reg <= B_MUL;
                    d_reg     <= '0;
                end
                B_MUL: begin
                    if (d_reg == 2'd0) begin
                        g_reg[0] <= rd_data[150:119];
                        g_reg[1] <= rd_data[118:87];
                        g_reg[2] <= rd_data[86:55];
                        mass_reg <= rd_data[54:24];
                        nidx_reg <= rd_data[23:0];
                        d_reg    <= 2'd1;
                        p_reg[0] <= $signed(rd_data[150:119]) * job_reg.sum_x;
                    end else begin
                        p_reg[d_reg] <= g_sel * s_sel;
                        if (d_reg == 2'd2) begin
                            state_reg <= B_DOT;
                        end
                        d_reg <= d_reg + 2'd1;
                    end
                end
                B_DOT: begin
                    dot_reg   <= sat32(dot_sum);
                    state_reg <= B_FLUX;
                end
                B_FLUX: begin
                    flux_reg  <= sat32(66'(flux_prod >>> 16));
                    state_reg <= B_NUM;
                end
                B_NUM: begin
                    neg_reg   <= num_full[63];
                    quo_reg   <= num_full[63] ? 63'(-num_full) : num_full[62:0];
                    rem_reg   <= '0;
                    bit_reg   <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    if (!trial[63]) begin
                        rem_reg <= trial[62:0];
                        quo_reg <= {quo_reg[61:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[61:0], quo_reg[62]};
                        quo_reg <= {quo_reg[61:0], 1'b0};
                    end
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd62) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg.temp_increment <= (mass_reg == '0) ? 32'sd0
                                                  : sat32(-66'(qs));
                        out_reg.out_node_index <= nidx_reg;
                        out_reg.last_result    <= ({1'b0, idx_reg} + 4'd1 == job_reg.count);
                        out_valid_reg          <= 1'b1;
                        idx_reg                <= idx_reg + 3'd1;
                        state_reg <= ({1'b0, idx_reg} + 4'd1 == job_reg.count) ? B_IDLE
                                                                               : B_READ;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/ehc_queue.sv
// short job queue between front and back
module ehc_queue
    import ehc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ehc_job_t in_job,
    output logic     out_valid,
    input  logic     out_ready,
    output ehc_job_t out_job
);
    ehc_job_t   slot_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = cnt_reg != 2'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = slot_reg[rp_reg];

    // pointer and count update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) begin
                slot_reg[wp_reg] <= in_job;
                wp_reg <= ~wp_reg;
            end
            if (out_valid && out_ready) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end
endmodule

// File: hw/rtl/element_heat_conduction_step.sv
// top level of the element heat conduction step block
// Usage: one transfer on s_ per node of an element; last_node closes the element.
// The register port (cfg_valid/cfg_ready/cfg_data) sets time_step; write it idle.
// Front end takes a node and stores it in a ram, then multiplies on one
// multiplier, one dimension a cycle, and accumulates before it takes the next node.
// On the last node the element's sums move through a two entry queue to the
// back end, which walks the stored nodes: per node it reads the node, forms
// the dot product, scales it by the conductance and the time step, divides
// it bit serially by the mass and outputs the result before the next node.
// Results leave through an output register on m_; a stalled receiver holds it
// and the back end waits. Extra nodes beyond MAX_NODES are dropped.
// Reset (aresetn low, synchronous) clears sums, counters, queue and time_step.
// s_ready stays low while a job waits in the queue or the back end is busy, so
// the next element never overwrites node ram entries that are still being read.
`include "element_heat_conduction_step_defines.svh"
module element_heat_conduction_step
    import ehc_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int DIMS      = DIMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  ehc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ehc_out_t    m_data
);
    logic [30:0]  time_step_reg;
    logic         st_we, f_ready, j_valid, j_ready, q_valid, q_ready, back_busy;
    logic [2:0]   st_addr, rd_addr;
    logic [150:0] st_wdata, rd_data;
    ehc_job_t     j_job, q_job;

    assign cfg_ready = 1'b1;
    // hold new nodes while the back end still reads the node ram
    assign back_busy = !q_ready || q_valid;
    assign s_ready   = f_ready && !back_busy;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            time_step_reg <= cfg_data;
        end
    end

    ehc_front #(.MAX_NODES(MAX_NODES), .DIMS(DIMS)) u_front (
        .aclk, .aresetn, .s_valid(s_valid && !back_busy), .s_ready(f_ready), .s_data,
        .st_we, .st_addr, .st_wdata,
        .job_valid(j_valid), .job_ready(j_ready), .job(j_job));

    ehc_ram #(.WIDTH(151), .DEPTH(SLOTS)) u_ram (
        .aclk, .we(st_we), .waddr(st_addr), .wdata(st_wdata),
        .raddr(rd_addr), .rdata(rd_data));

    ehc_queue u_queue (
        .aclk, .aresetn, .in_valid(j_valid), .in_ready(j_ready), .in_job(j_job),
        .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job));

    ehc_back u_back (
        .aclk, .aresetn, .time_step(time_step_reg),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .rd_addr, .rd_data, .m_valid, .m_ready, .m_data);

    `EHC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `EHC_ASSERT_IMP(a_no_write_busy, aclk, aresetn, st_we, !back_busy)
    `EHC_ASSERT_NXT(a_cfg_taken, aclk, aresetn, cfg_valid, time_step_reg == $past(cfg_data))
endmodule
